/* sv/rbp_pkg.sv */
// Shared types and constants for the replicate border padding unit.
// No dependencies; every other file refers to it by scoped names.
package rbp_pkg;

    localparam int PIX_W   = 8;
    localparam int SIZE_W  = 13;
    localparam int HALF_W  = 3;
    localparam int COORD_W = 13;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam int DEF_MAX_WIDTH     = 4096;
    localparam int DEF_MAX_HEIGHT    = 4096;
    localparam int DEF_MAX_HALF_MASK = 7;

    localparam logic [SIZE_W-1:0] RST_WIDTH  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] RST_HEIGHT = SIZE_W'(480);
    localparam logic [HALF_W-1:0] RST_HALF   = HALF_W'(1);

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_HALF_MASK    = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [HALF_W-1:0] half;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_stat;

endpackage

/* sv/rbp_regs.sv */
// Configuration register file behind the APB-style port.
// Depends on rbp_pkg for the register map and the config struct.
module rbp_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rbp_pkg::ADDR_W-1:0] paddr,
    input  logic [rbp_pkg::DATA_W-1:0] pwdata,
    output logic [rbp_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output rbp_pkg::t_cfg              o_cfg,
    output logic                       o_restart
);

    rbp_pkg::t_cfg r_cfg;
    logic [1:0]    idx;
    logic          wr;

    assign idx    = paddr[3:2];
    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= rbp_pkg::RST_WIDTH;
            r_cfg.height <= rbp_pkg::RST_HEIGHT;
            r_cfg.half   <= rbp_pkg::RST_HALF;
        end else if (wr) begin
            case (idx)
                rbp_pkg::REG_IMAGE_WIDTH:  r_cfg.width  <= pwdata[rbp_pkg::SIZE_W-1:0];
                rbp_pkg::REG_IMAGE_HEIGHT: r_cfg.height <= pwdata[rbp_pkg::SIZE_W-1:0];
                rbp_pkg::REG_HALF_MASK:    r_cfg.half   <= pwdata[rbp_pkg::HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // Any write to a known register restarts the image.
    always_comb begin
        case (idx)
            rbp_pkg::REG_IMAGE_WIDTH,
            rbp_pkg::REG_IMAGE_HEIGHT,
            rbp_pkg::REG_HALF_MASK: o_restart = wr;
            default:                o_restart = 1'b0;
        endcase
    end

    always_comb begin
        case (idx)
            rbp_pkg::REG_IMAGE_WIDTH:  prdata = rbp_pkg::DATA_W'(r_cfg.width);
            rbp_pkg::REG_IMAGE_HEIGHT: prdata = rbp_pkg::DATA_W'(r_cfg.height);
            rbp_pkg::REG_HALF_MASK:    prdata = rbp_pkg::DATA_W'(r_cfg.half);
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/rbp_ctrl.sv */
// Controller state machine: accepts items and walks each item's run.
// Depends on rbp_pkg for the command and status structs.
module rbp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  rbp_pkg::t_dp_stat i_stat,
    output rbp_pkg::t_dp_cmd  o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic r_state;
    logic n_state;
    logic in_acc;

    // A new item may enter as the last result of the current run leaves.
    assign o_in_stall  = !((r_state == ST_IDLE) || (i_stat.last && !i_out_stall));
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == ST_RUN);

    always_comb begin
        n_state    = r_state;
        o_cmd.load = in_acc;
        o_cmd.step = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (!i_out_stall) begin
                    if (i_stat.last) begin
                        n_state = in_acc ? ST_RUN : ST_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/rbp_datapath.sv */
// Datapath: pixel position counters, run bounds and the output coordinates.
// Depends on rbp_pkg for field widths, the config struct and command structs.
module rbp_datapath #(
    parameter int MAX_WIDTH     = rbp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = rbp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_HALF_MASK = rbp_pkg::DEF_MAX_HALF_MASK
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rbp_pkg::t_cfg               i_cfg,
    input  logic                        i_restart,
    input  rbp_pkg::t_dp_cmd            i_cmd,
    output rbp_pkg::t_dp_stat           o_stat,
    input  logic [rbp_pkg::PIX_W-1:0]   i_pixel_in,
    output logic [rbp_pkg::COORD_W-1:0] o_out_col,
    output logic [rbp_pkg::COORD_W-1:0] o_out_row,
    output logic [rbp_pkg::PIX_W-1:0]   o_pixel_out
);

    localparam int CW    = rbp_pkg::COORD_W;
    localparam int EXT_W = rbp_pkg::SIZE_W + 1;
    localparam int CNT_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [CNT_W-1:0]           r_ccnt, n_ccnt;
    logic [ROW_W-1:0]           r_rcnt, n_rcnt;
    logic [CW-1:0]              r_col, r_row, r_cs, r_ce, r_re;
    logic [rbp_pkg::PIX_W-1:0]  r_pix;

    logic [EXT_W-1:0]           w_eff, h_ext_sz, wext, hext;
    logic [rbp_pkg::HALF_W-1:0] h_eff, h_clamp;
    logic [EXT_W-1:0]           half_ext, c_ext, r_ext, c_pos, r_pos;
    logic                       col_last, row_last;
    logic [CW-1:0]              cs, ce, rs, re;

    // Effective sizes: zero is used as one, oversize saturates.
    assign wext = {1'b0, i_cfg.width};
    assign hext = {1'b0, i_cfg.height};
    assign w_eff = (i_cfg.width == '0) ? EXT_W'(1) :
                   (wext > EXT_W'(MAX_WIDTH)) ? EXT_W'(MAX_WIDTH) : wext;
    assign h_ext_sz = (i_cfg.height == '0) ? EXT_W'(1) :
                      (hext > EXT_W'(MAX_HEIGHT)) ? EXT_W'(MAX_HEIGHT) : hext;
    assign h_clamp = (i_cfg.half > rbp_pkg::HALF_W'(MAX_HALF_MASK)) ?
                     rbp_pkg::HALF_W'(MAX_HALF_MASK) : i_cfg.half;
    // A single line or column keeps the border at three at most.
    assign h_eff = ((w_eff == EXT_W'(1) || h_ext_sz == EXT_W'(1)) &&
                    h_clamp > rbp_pkg::HALF_W'(3)) ? rbp_pkg::HALF_W'(3) : h_clamp;

    assign half_ext = EXT_W'(h_eff);
    assign c_ext    = EXT_W'(r_ccnt);
    assign r_ext    = EXT_W'(r_rcnt);
    assign c_pos    = c_ext + half_ext;
    assign r_pos    = r_ext + half_ext;
    assign col_last = (c_ext + EXT_W'(1)) >= w_eff;
    assign row_last = (r_ext + EXT_W'(1)) >= h_ext_sz;

    // Each axis covers one contiguous range of padded coordinates.
    assign cs = (r_ccnt == '0) ? '0 : c_pos[CW-1:0];
    assign rs = (r_rcnt == '0) ? '0 : r_pos[CW-1:0];
    assign ce = col_last ? CW'(w_eff + {half_ext[EXT_W-2:0], 1'b0} - EXT_W'(1))
                         : c_pos[CW-1:0];
    assign re = row_last ? CW'(h_ext_sz + {half_ext[EXT_W-2:0], 1'b0} - EXT_W'(1))
                         : r_pos[CW-1:0];

    always_comb begin
        n_ccnt = r_ccnt;
        n_rcnt = r_rcnt;
        if (i_restart) begin
            n_ccnt = '0;
            n_rcnt = '0;
        end else if (i_cmd.load) begin
            if (col_last) begin
                n_ccnt = '0;
                n_rcnt = row_last ? '0 : r_rcnt + ROW_W'(1);
            end else begin
                n_ccnt = r_ccnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccnt <= '0;
            r_rcnt <= '0;
        end else begin
            r_ccnt <= n_ccnt;
            r_rcnt <= n_rcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cs  <= cs;
            r_ce  <= ce;
            r_re  <= re;
            r_col <= cs;
            r_row <= rs;
            r_pix <= i_pixel_in;
        end else if (i_cmd.step) begin
            if (r_col == r_ce) begin
                r_col <= r_cs;
                r_row <= r_row + CW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    assign o_stat.last = (r_col == r_ce) && (r_row == r_re);
    assign o_out_col   = r_col;
    assign o_out_row   = r_row;
    assign o_pixel_out = r_pix;

endmodule

/* sv/replicate_border_padding_unit.sv */
// Replicate border padding: one result per cycle while i_out_stall is low, the first
// in the cycle after the item is taken. An item yields (1 + left + right border) x
// (1 + top + bottom border) results, where a border counts only for a pixel on that
// edge, walked in raster order by the run counters in the datapath; an interior pixel
// yields one result, and the next item is accepted as the last result of a run leaves.
// Reset is synchronous, active low: registers return to their defaults, the pixel
// position counters to zero; no clearing pass is needed.
module replicate_border_padding_unit #(
    parameter int MAX_WIDTH     = rbp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = rbp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_HALF_MASK = rbp_pkg::DEF_MAX_HALF_MASK
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rbp_pkg::ADDR_W-1:0]  paddr,
    input  logic [rbp_pkg::DATA_W-1:0]  pwdata,
    output logic [rbp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [rbp_pkg::PIX_W-1:0]   i_pixel_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [rbp_pkg::COORD_W-1:0] o_out_col,
    output logic [rbp_pkg::COORD_W-1:0] o_out_row,
    output logic [rbp_pkg::PIX_W-1:0]   o_pixel_out,
    output logic                        o_last_of_run
);

    rbp_pkg::t_cfg     cfg;
    logic              restart;
    rbp_pkg::t_dp_cmd  cmd;
    rbp_pkg::t_dp_stat stat;

    rbp_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_restart (restart)
    );

    rbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rbp_datapath #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .MAX_HALF_MASK (MAX_HALF_MASK)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_restart   (restart),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_pixel_in  (i_pixel_in),
        .o_out_col   (o_out_col),
        .o_out_row   (o_out_row),
        .o_pixel_out (o_pixel_out)
    );

    assign o_last_of_run = o_out_valid & stat.last;

`ifndef ASSERT_OFF
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted item produced no result");

    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_of_run) |-> o_in_stall)
        else $error("item accepted in the middle of a run");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_of_run && !i_out_stall) |=> o_out_valid)
        else $error("run ended without its last result");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_run && !i_out_stall && !i_in_valid) |=> !o_out_valid)
        else $error("result shown after the run ended");
`endif

endmodule
